[sv/assert_macros.svh]
// Shared assertion macros.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// cons must hold in the cycle after ante
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// cons must hold in the same cycle as ante
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

[sv/frf_pkg.sv]
`default_nettype none
package frf_pkg;

   localparam int COORD_BITS = 12;
   localparam int SIZE_BITS  = COORD_BITS + 1;
   localparam logic [SIZE_BITS-1:0] COORD_MAX = SIZE_BITS'(1) << COORD_BITS;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;
   localparam int DEPTH_W     = 3;
   localparam int STRIDE_W    = 16;
   localparam int ADDR_W      = 32;
   localparam int DATA_W      = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_DEPTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STRIDE = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BASE   = 2'd2;

   localparam logic [DEPTH_W-1:0] DEPTH_1BPP  = 3'd0;
   localparam logic [DEPTH_W-1:0] DEPTH_4BPP  = 3'd1;
   localparam logic [DEPTH_W-1:0] DEPTH_8BPP  = 3'd2;
   localparam logic [DEPTH_W-1:0] DEPTH_16BPP = 3'd3;
   localparam logic [DEPTH_W-1:0] DEPTH_32BPP = 3'd4;

   localparam logic CMD_START   = 1'b0;
   localparam logic CMD_ADVANCE = 1'b1;

   localparam logic [1:0] UNIT_BYTE = 2'd0;
   localparam logic [1:0] UNIT_HALF = 2'd1;
   localparam logic [1:0] UNIT_WORD = 2'd2;

   localparam logic [7:0] MASK_FULL = 8'hff;
   localparam logic [7:0] MASK_LO   = 8'h0f;
   localparam logic [7:0] MASK_HI   = 8'hf0;

   localparam logic [4:0] GRAY_R = 5'd11;
   localparam logic [4:0] GRAY_G = 5'd16;
   localparam logic [4:0] GRAY_B = 5'd5;
   localparam int GRAY_SHIFT = 5;  // divide by 32

endpackage
`default_nettype wire

[sv/frf_channels.sv]
`default_nettype none
interface frf_req_if;
   import frf_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  cmd;
   logic [COORD_BITS-1:0] rect_x;
   logic [COORD_BITS-1:0] rect_y;
   logic [SIZE_BITS-1:0]  rect_width;
   logic [SIZE_BITS-1:0]  rect_height;
   logic [7:0]            red;
   logic [7:0]            green;
   logic [7:0]            blue;
   logic [DATA_W-1:0]     pixel_value;

   modport source (output valid, cmd, rect_x, rect_y, rect_width, rect_height,
                   red, green, blue, pixel_value, input ready);
   modport sink   (input valid, cmd, rect_x, rect_y, rect_width, rect_height,
                   red, green, blue, pixel_value, output ready);
endinterface

interface frf_rsp_if;
   import frf_pkg::*;

   logic              valid;
   logic              ready;
   logic              write_valid;
   logic [ADDR_W-1:0] write_address;
   logic [DATA_W-1:0] write_data;
   logic [7:0]        bit_mask;
   logic [1:0]        unit_size;
   logic              last;
   logic              error;

   modport source (output valid, write_valid, write_address, write_data, bit_mask,
                   unit_size, last, error, input ready);
   modport sink   (input valid, write_valid, write_address, write_data, bit_mask,
                   unit_size, last, error, output ready);
endinterface
`default_nettype wire

[sv/framebuffer_rect_fill_unit.sv]
// Solid rectangle fill engine. A start item latches the rectangle, colour and
// pixel value and answers with no write (last set when the fill is empty,
// error and last set for an unsupported depth); each advance item while the
// fill runs answers with one framebuffer write, rows top to bottom, each row
// whole body units between optional masked head and tail bytes. An item is
// accepted whenever the result register is empty or being drained, its result
// appears in that register on the next cycle, and a new item can enter every
// cycle while results drain. Depth, stride and base are sampled at start; the
// start path holds one 12x16 multiply (row * stride) and two adds.
`default_nettype none
`include "assert_macros.svh"
module framebuffer_rect_fill_unit (
   input  wire                                clock,
   input  wire                                reset,
   frf_req_if.sink                            req_chan,
   frf_rsp_if.source                          rsp_chan,
   input  wire                                csr_write_enable,
   input  wire [frf_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire [frf_pkg::CSR_DATA_W-1:0]      csr_write_data
);
   import frf_pkg::*;

   typedef enum logic [1:0] {PH_HEAD, PH_BODY, PH_TAIL, PH_END} phase_type;

   // configuration
   logic [DEPTH_W-1:0]  depth_ff;
   logic [STRIDE_W-1:0] stride_ff;
   logic [ADDR_W-1:0]   base_ff;

   // fill state
   logic                 busy_ff, busy_in;
   phase_type            phase_ff, phase_in;
   logic [ADDR_W-1:0]    row_addr_ff, row_addr_in;
   logic [SIZE_BITS-1:0] rows_ff, rows_in;
   logic [SIZE_BITS-1:0] units_ff, units_in;
   logic [SIZE_BITS-1:0] body_ff, body_in;
   logic [DATA_W-1:0]    fill_ff, fill_in;
   logic [7:0]           head_ff, head_in;
   logic [7:0]           tail_ff, tail_in;
   logic [1:0]           kind_ff, kind_in;
   logic [STRIDE_W-1:0]  hstride_ff, hstride_in;

   // result register
   logic              rsp_valid_ff;
   logic              wvalid_ff, wvalid_in;
   logic [ADDR_W-1:0] waddr_ff, waddr_in;
   logic [DATA_W-1:0] wdata_ff, wdata_in;
   logic [7:0]        wmask_ff, wmask_in;
   logic [1:0]        wsize_ff, wsize_in;
   logic              last_ff, last_in;
   logic              err_ff, err_in;

   logic                 accept;
   logic                 do_settle;
   logic [SIZE_BITS-1:0] w_sat, h_sat;
   logic [12:0]          gray_sum;
   logic [7:0]           gray;
   logic [ADDR_W-1:0]    line_addr;
   logic [2:0]           off;
   logic [2:0]           aw_full;
   logic [2:0]           aw;
   logic [3:0]           head_end;
   logic [SIZE_BITS-1:0] w_rest;
   logic [2:0]           tw;
   logic [SIZE_BITS-1:0] idx;
   logic [ADDR_W-1:0]    body_off;
   logic [ADDR_W-1:0]    lead;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.write_valid   = wvalid_ff;
   assign rsp_chan.write_address = waddr_ff;
   assign rsp_chan.write_data    = wdata_ff;
   assign rsp_chan.bit_mask      = wmask_ff;
   assign rsp_chan.unit_size     = wsize_ff;
   assign rsp_chan.last          = last_ff;
   assign rsp_chan.error         = err_ff;

   assign w_sat = (req_chan.rect_width > COORD_MAX) ? COORD_MAX : req_chan.rect_width;
   assign h_sat = (req_chan.rect_height > COORD_MAX) ? COORD_MAX : req_chan.rect_height;

   assign gray_sum = {5'd0, req_chan.red} * 13'(GRAY_R)
                   + {5'd0, req_chan.green} * 13'(GRAY_G)
                   + {5'd0, req_chan.blue} * 13'(GRAY_B);
   assign gray     = gray_sum[GRAY_SHIFT +: 8];

   assign line_addr = base_ff + ADDR_W'(req_chan.rect_y) * ADDR_W'(stride_ff);

   // 1bpp head/tail geometry
   assign off      = req_chan.rect_x[2:0];
   assign aw_full  = 3'd0 - off;
   assign aw       = (SIZE_BITS'(aw_full) > w_sat) ? w_sat[2:0] : aw_full;
   assign head_end = {1'b0, off} + {1'b0, aw};
   assign w_rest   = w_sat - SIZE_BITS'(aw);
   assign tw       = w_rest[2:0];

   assign idx      = body_ff - units_ff;
   assign body_off = ADDR_W'(idx) << kind_ff;
   assign lead     = (head_ff != 8'd0) ? ADDR_W'(1) : ADDR_W'(0);

   always_comb begin
      busy_in     = busy_ff;
      phase_in    = phase_ff;
      row_addr_in = row_addr_ff;
      rows_in     = rows_ff;
      units_in    = units_ff;
      body_in     = body_ff;
      fill_in     = fill_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      kind_in     = kind_ff;
      hstride_in  = hstride_ff;
      wvalid_in   = 1'b0;
      waddr_in    = '0;
      wdata_in    = '0;
      wmask_in    = '0;
      wsize_in    = UNIT_BYTE;
      last_in     = 1'b0;
      err_in      = 1'b0;
      do_settle   = 1'b0;

      if (accept) begin
         if (req_chan.cmd == CMD_START) begin
            busy_in    = 1'b0;
            head_in    = 8'd0;
            tail_in    = 8'd0;
            hstride_in = stride_ff;
            phase_in   = PH_HEAD;
            if (depth_ff > DEPTH_32BPP) begin
               err_in  = 1'b1;
               last_in = 1'b1;
            end else if (w_sat == '0 || h_sat == '0) begin
               last_in = 1'b1;
            end else begin
               case (depth_ff)
                  DEPTH_1BPP: begin
                     head_in     = (MASK_FULL >> off) & ~(MASK_FULL >> head_end);
                     tail_in     = ~(MASK_FULL >> tw);
                     body_in     = w_rest >> 3;
                     fill_in     = gray[7] ? DATA_W'(MASK_FULL) : '0;
                     row_addr_in = line_addr + ADDR_W'(req_chan.rect_x >> 3);
                     kind_in     = UNIT_BYTE;
                  end
                  DEPTH_4BPP: begin
                     head_in     = req_chan.rect_x[0] ? MASK_LO : 8'd0;
                     tail_in     = (w_sat[0] ^ req_chan.rect_x[0]) ? MASK_HI : 8'd0;
                     body_in     = (w_sat - SIZE_BITS'(req_chan.rect_x[0])) >> 1;
                     fill_in     = DATA_W'({gray[7:4], gray[7:4]});
                     row_addr_in = line_addr + ADDR_W'(req_chan.rect_x >> 1);
                     kind_in     = UNIT_BYTE;
                  end
                  DEPTH_8BPP: begin
                     body_in     = w_sat;
                     fill_in     = DATA_W'(req_chan.pixel_value[7:0]);
                     row_addr_in = line_addr + ADDR_W'(req_chan.rect_x);
                     kind_in     = UNIT_BYTE;
                  end
                  DEPTH_16BPP: begin
                     body_in     = w_sat;
                     fill_in     = DATA_W'(req_chan.pixel_value[15:0]);
                     row_addr_in = line_addr + (ADDR_W'(req_chan.rect_x) << 1);
                     kind_in     = UNIT_HALF;
                  end
                  default: begin
                     body_in     = w_sat;
                     fill_in     = req_chan.pixel_value;
                     row_addr_in = line_addr + (ADDR_W'(req_chan.rect_x) << 2);
                     kind_in     = UNIT_WORD;
                  end
               endcase
               rows_in   = h_sat;
               units_in  = body_in;
               busy_in   = 1'b1;
               do_settle = 1'b1;
            end
         end else if (busy_ff) begin
            wvalid_in = 1'b1;
            do_settle = 1'b1;
            case (phase_ff)
               PH_HEAD: begin
                  waddr_in = row_addr_ff;
                  wmask_in = head_ff;
                  wdata_in = fill_ff & DATA_W'(head_ff);
                  phase_in = PH_BODY;
               end
               PH_BODY: begin
                  waddr_in = row_addr_ff + lead + body_off;
                  wmask_in = MASK_FULL;
                  wsize_in = kind_ff;
                  wdata_in = fill_ff;
                  units_in = units_ff - SIZE_BITS'(1);
               end
               default: begin
                  waddr_in = row_addr_ff + lead + ADDR_W'(body_ff);
                  wmask_in = tail_ff;
                  wdata_in = fill_ff & DATA_W'(tail_ff);
                  phase_in = PH_END;
               end
            endcase
         end

         // step to the next unit that exists; every row holds at least one
         if (do_settle) begin
            if (phase_in == PH_HEAD && head_in != 8'd0) begin
               phase_in = PH_HEAD;
            end else if ((phase_in == PH_HEAD || phase_in == PH_BODY) && units_in != '0) begin
               phase_in = PH_BODY;
            end else if (phase_in != PH_END && tail_in != 8'd0) begin
               phase_in = PH_TAIL;
            end else if (rows_in <= SIZE_BITS'(1)) begin
               rows_in  = '0;
               busy_in  = 1'b0;
               phase_in = PH_END;
            end else begin
               rows_in     = rows_in - SIZE_BITS'(1);
               row_addr_in = row_addr_in + ADDR_W'(hstride_in);
               units_in    = body_in;
               if (head_in != 8'd0) begin
                  phase_in = PH_HEAD;
               end else if (body_in != '0) begin
                  phase_in = PH_BODY;
               end else begin
                  phase_in = PH_TAIL;
               end
            end
            last_in = !busy_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff  <= DEPTH_32BPP;
         stride_ff <= '0;
         base_ff   <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_DEPTH:  depth_ff  <= csr_write_data[DEPTH_W-1:0];
            CSR_STRIDE: stride_ff <= csr_write_data[STRIDE_W-1:0];
            CSR_BASE:   base_ff   <= csr_write_data[ADDR_W-1:0];
            default:    ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         phase_ff     <= PH_HEAD;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         phase_ff <= phase_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      row_addr_ff <= row_addr_in;
      rows_ff     <= rows_in;
      units_ff    <= units_in;
      body_ff     <= body_in;
      fill_ff     <= fill_in;
      head_ff     <= head_in;
      tail_ff     <= tail_in;
      kind_ff     <= kind_in;
      hstride_ff  <= hstride_in;
      if (accept) begin
         wvalid_ff <= wvalid_in;
         waddr_ff  <= waddr_in;
         wdata_ff  <= wdata_in;
         wmask_ff  <= wmask_in;
         wsize_ff  <= wsize_in;
         last_ff   <= last_in;
         err_ff    <= err_in;
      end
   end

   `ASSERT_ALWAYS(a_busy_not_row_end, clock, reset, !busy_ff || phase_ff != PH_END, "busy fill parked at row end")
   `ASSERT_SAME(a_error_no_write, clock, reset, rsp_valid_ff && err_ff, !wvalid_ff && last_ff, "error item carries a write or lacks last")
   `ASSERT_NEXT(a_idle_advance_silent, clock, reset, accept && req_chan.cmd == CMD_ADVANCE && !busy_ff, rsp_valid_ff && !wvalid_ff && !last_ff, "advance while idle produced a write")
   `ASSERT_SAME(a_partial_is_byte, clock, reset, rsp_valid_ff && wvalid_ff && wmask_ff != MASK_FULL, wsize_ff == UNIT_BYTE, "masked write wider than a byte")

endmodule
`default_nettype wire

[tb/framebuffer_rect_fill_unit_tb.sv]
`timescale 1ns / 1ps
module framebuffer_rect_fill_unit_tb;
   import frf_pkg::*;

   localparam int TOTAL_ITEMS = 1050;
   localparam int MAX_GAP     = 9;
   localparam int LONG_HOLD   = 120;

   typedef enum logic [1:0] {PH_HEAD, PH_BODY, PH_TAIL, PH_DONE} row_phase_type;

   typedef struct packed {
      logic                  cmd;
      logic [COORD_BITS-1:0] rect_x;
      logic [COORD_BITS-1:0] rect_y;
      logic [SIZE_BITS-1:0]  rect_width;
      logic [SIZE_BITS-1:0]  rect_height;
      logic [7:0]            red;
      logic [7:0]            green;
      logic [7:0]            blue;
      logic [DATA_W-1:0]     pixel_value;
   } fill_cmd_type;

   typedef struct packed {
      logic              write_valid;
      logic [ADDR_W-1:0] write_address;
      logic [DATA_W-1:0] write_data;
      logic [7:0]        bit_mask;
      logic [1:0]        unit_size;
      logic              last;
      logic              error;
   } fb_write_type;

   typedef struct {
      bit                  is_regs;
      logic [DEPTH_W-1:0]  depth;
      logic [STRIDE_W-1:0] stride;
      logic [ADDR_W-1:0]   base;
      fill_cmd_type        cmd;
      bit                  typed;
      fb_write_type        want;
   } plan_row_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   frf_req_if req_if();
   frf_rsp_if rsp_if();

   framebuffer_rect_fill_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_if),
      .rsp_chan         (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #10 clock = ~clock;

   // fill engine predictor state
   logic [DEPTH_W-1:0]   cur_depth = DEPTH_32BPP;
   logic [STRIDE_W-1:0]  cur_stride = '0;
   logic [ADDR_W-1:0]    cur_base = '0;
   bit                   fill_busy = 1'b0;
   logic [ADDR_W-1:0]    fill_row_addr = '0;
   logic [SIZE_BITS-1:0] fill_rows = '0;
   row_phase_type        fill_phase = PH_HEAD;
   logic [SIZE_BITS-1:0] fill_units = '0;
   logic [SIZE_BITS-1:0] fill_body = '0;
   logic [DATA_W-1:0]    fill_value = '0;
   logic [7:0]           fill_head = '0;
   logic [7:0]           fill_tail = '0;
   logic [1:0]           fill_unit = UNIT_BYTE;
   logic [STRIDE_W-1:0]  fill_stride = '0;

   fb_write_type writes_due[$];
   int           mismatches = 0;
   int           items_sent = 0;
   int           req_gap = 0;
   bit           req_up = 1'b0;
   bit           req_burst = 1'b0;
   bit           rsp_burst = 1'b0;
   bit           hold_rsp = 1'b0;

   // step to the next unit that exists, or finish the fill
   function automatic void seek_unit();
      forever begin
         case (fill_phase)
            PH_HEAD: begin
               if (fill_head != 0) return;
               fill_phase = PH_BODY;
            end
            PH_BODY: begin
               if (fill_units != 0) return;
               fill_phase = PH_TAIL;
            end
            PH_TAIL: begin
               if (fill_tail != 0) return;
               fill_phase = PH_DONE;
            end
            default: begin
               if (fill_rows <= 1) begin
                  fill_rows = '0;
                  fill_busy = 1'b0;
                  return;
               end
               fill_rows--;
               fill_row_addr += 32'(fill_stride);
               fill_phase = PH_HEAD;
               fill_units = fill_body;
            end
         endcase
      end
   endfunction

   function automatic fb_write_type fill_step(input fill_cmd_type c);
      fb_write_type         o;
      logic [SIZE_BITS-1:0] w, h;
      logic [31:0]          gray, line, lead, idx;
      int                   off, aw, tw, al;
      o = '0;
      if (c.cmd == CMD_START) begin
         w = (c.rect_width > COORD_MAX) ? COORD_MAX : c.rect_width;
         h = (c.rect_height > COORD_MAX) ? COORD_MAX : c.rect_height;
         gray = (32'(c.red) * 32'(GRAY_R) + 32'(c.green) * 32'(GRAY_G)
                 + 32'(c.blue) * 32'(GRAY_B)) >> GRAY_SHIFT;
         line = cur_base + 32'(c.rect_y) * 32'(cur_stride);
         fill_busy = 1'b0;
         fill_head = '0;
         fill_tail = '0;
         fill_stride = cur_stride;
         fill_phase = PH_HEAD;
         if (cur_depth > DEPTH_32BPP) begin
            o.error = 1'b1;
            o.last = 1'b1;
         end else if (w == 0 || h == 0) begin
            o.last = 1'b1;
         end else begin
            case (cur_depth)
               DEPTH_1BPP: begin
                  off = int'(c.rect_x[2:0]);
                  aw = (8 - off) % 8;
                  if (aw > int'(w)) aw = int'(w);
                  if (aw != 0) fill_head = 8'(((1 << aw) - 1) << (8 - off - aw));
                  tw = (int'(w) - aw) % 8;
                  if (tw != 0) fill_tail = 8'(MASK_FULL << (8 - tw));
                  fill_body = SIZE_BITS'((int'(w) - aw) / 8);
                  fill_value = gray[7] ? 32'(MASK_FULL) : '0;
                  fill_row_addr = line + 32'(c.rect_x >> 3);
                  fill_unit = UNIT_BYTE;
               end
               DEPTH_4BPP: begin
                  al = int'(c.rect_x[0]);
                  if (al != 0) fill_head = MASK_LO;
                  if (((int'(w) - al) % 2) != 0) fill_tail = MASK_HI;
                  fill_body = SIZE_BITS'((int'(w) - al) / 2);
                  fill_value = {24'd0, gray[7:4], gray[7:4]};
                  fill_row_addr = line + 32'(c.rect_x >> 1);
                  fill_unit = UNIT_BYTE;
               end
               DEPTH_8BPP: begin
                  fill_body = w;
                  fill_value = {24'd0, c.pixel_value[7:0]};
                  fill_row_addr = line + 32'(c.rect_x);
                  fill_unit = UNIT_BYTE;
               end
               DEPTH_16BPP: begin
                  fill_body = w;
                  fill_value = {16'd0, c.pixel_value[15:0]};
                  fill_row_addr = line + 32'(c.rect_x) * 2;
                  fill_unit = UNIT_HALF;
               end
               default: begin
                  fill_body = w;
                  fill_value = c.pixel_value;
                  fill_row_addr = line + 32'(c.rect_x) * 4;
                  fill_unit = UNIT_WORD;
               end
            endcase
            fill_rows = h;
            fill_units = fill_body;
            fill_busy = 1'b1;
            seek_unit();
            if (!fill_busy) o.last = 1'b1;
         end
      end else if (fill_busy) begin
         lead = (fill_head != 0) ? 32'd1 : 32'd0;
         o.write_valid = 1'b1;
         case (fill_phase)
            PH_HEAD: begin
               o.write_address = fill_row_addr;
               o.bit_mask = fill_head;
               o.write_data = fill_value & {24'd0, fill_head};
               o.unit_size = UNIT_BYTE;
               fill_phase = PH_BODY;
            end
            PH_BODY: begin
               idx = 32'(fill_body - fill_units);
               o.write_address = fill_row_addr + lead + (idx << fill_unit);
               o.bit_mask = MASK_FULL;
               o.unit_size = fill_unit;
               o.write_data = (fill_unit == UNIT_BYTE) ? (fill_value & 32'(MASK_FULL))
                                                       : fill_value;
               fill_units--;
            end
            default: begin
               o.write_address = fill_row_addr + lead + 32'(fill_body);
               o.bit_mask = fill_tail;
               o.write_data = fill_value & {24'd0, fill_tail};
               o.unit_size = UNIT_BYTE;
               fill_phase = PH_DONE;
            end
         endcase
         seek_unit();
         if (!fill_busy) o.last = 1'b1;
      end
      return o;
   endfunction

   function automatic fill_cmd_type start_cmd(input int x, input int y,
                                              input int w, input int h,
                                              input logic [7:0] r, input logic [7:0] g,
                                              input logic [7:0] b, input logic [31:0] pix);
      fill_cmd_type c;
      c.cmd = CMD_START;
      c.rect_x = COORD_BITS'(x);
      c.rect_y = COORD_BITS'(y);
      c.rect_width = SIZE_BITS'(w);
      c.rect_height = SIZE_BITS'(h);
      c.red = r;
      c.green = g;
      c.blue = b;
      c.pixel_value = pix;
      return c;
   endfunction

   function automatic fill_cmd_type adv_cmd();
      fill_cmd_type c;
      c = '0;
      c.cmd = CMD_ADVANCE;
      return c;
   endfunction

   function automatic fb_write_type wr(input logic v, input logic [31:0] a,
                                       input logic [31:0] d, input logic [7:0] m,
                                       input logic [1:0] s, input logic l, input logic e);
      return {v, a, d, m, s, l, e};
   endfunction

   function automatic plan_row_type regs_row(input logic [DEPTH_W-1:0] d,
                                             input logic [STRIDE_W-1:0] s,
                                             input logic [ADDR_W-1:0] b);
      return '{1'b1, d, s, b, '0, 1'b0, '0};
   endfunction

   function automatic plan_row_type chk_row(input fill_cmd_type c, input fb_write_type w);
      return '{1'b0, '0, '0, '0, c, 1'b1, w};
   endfunction

   function automatic plan_row_type run_row(input fill_cmd_type c);
      return '{1'b0, '0, '0, '0, c, 1'b0, '0};
   endfunction

   function automatic logic [SIZE_BITS-1:0] pick_size(input int most);
      case ($urandom_range(0, 11))
         0: return SIZE_BITS'($urandom_range(0, 8191));
         1: return '0;
         2: return COORD_MAX;
         default: return SIZE_BITS'($urandom_range(1, most));
      endcase
   endfunction

   function automatic fill_cmd_type random_fill_cmd();
      fill_cmd_type c;
      c.cmd = CMD_START;
      c.rect_x = COORD_BITS'($urandom_range(0, 4095));
      c.rect_y = COORD_BITS'($urandom_range(0, 4095));
      c.rect_width = pick_size(24);
      c.rect_height = pick_size(4);
      c.red = 8'($urandom_range(0, 255));
      c.green = 8'($urandom_range(0, 255));
      c.blue = 8'($urandom_range(0, 255));
      c.pixel_value = $urandom;
      return c;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      mismatches++;
   endtask

   task automatic check_write(input fb_write_type got);
      fb_write_type want;
      if (writes_due.size() == 0) begin
         report_mismatch("unexpected item", 32'(got.write_valid), '0);
         return;
      end
      want = writes_due.pop_front();
      if (got.write_valid !== want.write_valid)
         report_mismatch("write_valid", 32'(got.write_valid), 32'(want.write_valid));
      if (got.write_address !== want.write_address)
         report_mismatch("write_address", got.write_address, want.write_address);
      if (got.write_data !== want.write_data)
         report_mismatch("write_data", got.write_data, want.write_data);
      if (got.bit_mask !== want.bit_mask)
         report_mismatch("bit_mask", 32'(got.bit_mask), 32'(want.bit_mask));
      if (got.unit_size !== want.unit_size)
         report_mismatch("unit_size", 32'(got.unit_size), 32'(want.unit_size));
      if (got.last !== want.last)
         report_mismatch("last", 32'(got.last), 32'(want.last));
      if (got.error !== want.error)
         report_mismatch("error", 32'(got.error), 32'(want.error));
   endtask

   task automatic offer(input fill_cmd_type c, input bit typed = 1'b0,
                        input fb_write_type want = '0);
      fb_write_type predicted;
      if (req_gap > 0) repeat (req_gap) @(posedge clock);
      req_if.valid <= 1'b1;
      {req_if.cmd, req_if.rect_x, req_if.rect_y, req_if.rect_width, req_if.rect_height,
       req_if.red, req_if.green, req_if.blue, req_if.pixel_value} <= c;
      @(posedge clock);
      while (req_if.ready !== 1'b1) @(posedge clock);
      predicted = fill_step(c);
      writes_due.push_back(typed ? want : predicted);
      items_sent++;
      req_gap = req_burst ? 0 : $urandom_range(0, MAX_GAP);
      req_up = (req_gap == 0);
      if (!req_up) req_if.valid <= 1'b0;
   endtask

   task automatic wait_drained();
      if (req_up) begin
         req_if.valid <= 1'b0;
         req_up = 1'b0;
      end
      while (writes_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_cfg(input logic [DEPTH_W-1:0] d, input logic [STRIDE_W-1:0] s,
                            input logic [ADDR_W-1:0] b);
      wait_drained();
      csr_write_enable <= 1'b1;
      csr_index <= CSR_DEPTH;
      csr_write_data <= 32'(d);
      @(posedge clock);
      csr_index <= CSR_STRIDE;
      csr_write_data <= 32'(s);
      @(posedge clock);
      csr_index <= CSR_BASE;
      csr_write_data <= b;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cur_depth = d;
      cur_stride = s;
      cur_base = b;
   endtask

   initial begin
      #8_000_000;
      $display("FAIL");
      $finish;
   end

   initial begin : rsp_side
      fb_write_type got;
      int           gap;
      rsp_if.ready <= 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      gap = 0;
      forever begin
         if (gap > 0) repeat (gap) @(posedge clock);
         rsp_if.ready <= 1'b1;
         @(posedge clock);
         while (rsp_if.valid !== 1'b1) @(posedge clock);
         got = {rsp_if.write_valid, rsp_if.write_address, rsp_if.write_data,
                rsp_if.bit_mask, rsp_if.unit_size, rsp_if.last, rsp_if.error};
         check_write(got);
         if ($urandom_range(0, 39) == 0) rsp_burst = !rsp_burst;
         gap = rsp_burst ? 0 : $urandom_range(0, MAX_GAP);
         if (hold_rsp) begin
            gap = LONG_HOLD;
            hold_rsp = 1'b0;
         end
         if (gap > 0) rsp_if.ready <= 1'b0;
      end
   end

   initial begin : req_side
      plan_row_type        plan[$];
      fill_cmd_type        c;
      logic [DEPTH_W-1:0]  d;
      logic [STRIDE_W-1:0] s;
      logic [ADDR_W-1:0]   b;
      int                  phase_end, adv_budget, hold_at;
      reset <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_index <= CSR_DEPTH;
      csr_write_data <= '0;
      req_if.valid <= 1'b0;
      {req_if.cmd, req_if.rect_x, req_if.rect_y, req_if.rect_width, req_if.rect_height,
       req_if.red, req_if.green, req_if.blue, req_if.pixel_value} <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      plan = '{
         chk_row(adv_cmd(), '0),
         chk_row(start_cmd(1, 7, 1, 1, 8'h00, 8'h00, 8'h00, 32'hdeadbeef), '0),
         chk_row(adv_cmd(), wr(1, 32'h4, 32'hdeadbeef, MASK_FULL, UNIT_WORD, 1, 0)),
         chk_row(start_cmd(0, 0, 0, 5, 8'h00, 8'h00, 8'h00, 32'h0), wr(0, 0, 0, 0, 0, 1, 0)),
         regs_row(3'd5, 16'h0100, 32'h1000_0000),
         chk_row(start_cmd(2, 3, 4, 4, 8'hff, 8'hff, 8'hff, 32'hffff_ffff),
                 wr(0, 0, 0, 0, 0, 1, 1)),
         regs_row(3'd7, 16'h0100, 32'h1000_0000),
         chk_row(start_cmd(4095, 4095, 4096, 4096, 8'h00, 8'h00, 8'h00, 32'h0),
                 wr(0, 0, 0, 0, 0, 1, 1)),
         regs_row(DEPTH_1BPP, 16'd100, 32'h0000_2000),
         run_row(start_cmd(3, 1, 15, 1, 8'hff, 8'hff, 8'hff, 32'h0)),
         run_row(adv_cmd()),
         run_row(adv_cmd()),
         run_row(adv_cmd()),
         run_row(start_cmd(2, 0, 3, 1, 8'h00, 8'hff, 8'h00, 32'h0)),
         run_row(adv_cmd()),
         regs_row(DEPTH_4BPP, 16'hffff, 32'hffff_fff0),
         chk_row(start_cmd(1, 9, 0, 3, 8'hff, 8'hff, 8'hff, 32'h0), wr(0, 0, 0, 0, 0, 1, 0)),
         run_row(start_cmd(4095, 4095, 2, 1, 8'h80, 8'h40, 8'h20, 32'h0)),
         run_row(adv_cmd()),
         run_row(adv_cmd()),
         regs_row(DEPTH_8BPP, 16'd0, 32'd0),
         run_row(start_cmd(4095, 4095, 8191, 8191, 8'h00, 8'h00, 8'h00, 32'h1234_56a5)),
         run_row(adv_cmd()),
         run_row(start_cmd(0, 0, 1, 1, 8'h00, 8'h00, 8'h00, 32'h0000_005a)),
         run_row(adv_cmd())
      };
      foreach (plan[i]) begin
         if (plan[i].is_regs) write_cfg(plan[i].depth, plan[i].stride, plan[i].base);
         else offer(plan[i].cmd, plan[i].typed, plan[i].want);
      end

      // random fills; a phase may end mid-fill so later register writes hit a running fill
      phase_end = items_sent;
      hold_at = items_sent + 150;
      adv_budget = 0;
      while (items_sent < TOTAL_ITEMS) begin
         if (items_sent >= phase_end) begin
            d = ($urandom_range(0, 7) == 0) ? DEPTH_W'($urandom_range(5, 7))
                                            : DEPTH_W'($urandom_range(0, 4));
            case ($urandom_range(0, 5))
               0: s = '0;
               1: s = '1;
               default: s = STRIDE_W'($urandom_range(0, 65535));
            endcase
            case ($urandom_range(0, 5))
               0: b = '0;
               1: b = '1;
               default: b = $urandom;
            endcase
            write_cfg(d, s, b);
            phase_end = items_sent + $urandom_range(15, 70);
            req_burst = ($urandom_range(0, 3) == 0);
         end
         if (items_sent == hold_at) begin
            hold_rsp = 1'b1;
            hold_at += 450;
         end
         c = random_fill_cmd();
         if (fill_busy && adv_budget > 0) begin
            c.cmd = CMD_ADVANCE;
            adv_budget--;
         end else if ($urandom_range(0, 11) == 0) begin
            c.cmd = CMD_ADVANCE;
         end else begin
            adv_budget = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4)
                                                     : $urandom_range(20, 70);
         end
         offer(c);
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (mismatches == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule

[sim.f]
+incdir+sv
sv/frf_pkg.sv
sv/frf_channels.sv
sv/framebuffer_rect_fill_unit.sv
tb/framebuffer_rect_fill_unit_tb.sv
